>>> rtl/mcsm_pkg.sv
// Shared types, codes and size defaults for the MIDI chord sequence matcher.
// No dependencies; used by mcsm_ctrl, mcsm_dp and midi_chord_sequence_matcher.
package mcsm_pkg;

  localparam int MAX_MOMENTS_DEF            = 64;
  localparam int MAX_ACTIONS_DEF            = 256;
  localparam int MAX_ACTIONS_PER_MOMENT_DEF = 16;

  localparam int POS_W = 7;

  localparam logic [1:0] KIND_EVENT  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [6:0] volume;
    logic       ends_moment;
  } in_item_t;

  typedef struct packed {
    logic             matched;
    logic [1:0]       fail_signals;
    logic             moment_done;
    logic             song_done;
    logic [POS_W-1:0] position;
    logic             load_error;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MRD,
    S_PRIME,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic miss;
    logic hit;
    logic append;
    logic clear;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pos_ok;
    logic       hit;
    logic       scan_end;
    logic       retried;
    logic       out_free;
  } dp_status_t;

endpackage

>>> rtl/mcsm_ctrl.sv
// Sequencer for the matcher: dispatches items and steps the action scan.
// Depends on mcsm_pkg.
module mcsm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mcsm_pkg::dp_status_t   st,
  output mcsm_pkg::dp_cmd_t      cmd
);
  import mcsm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.kind)
          KIND_EVENT: begin
            state_next = S_MRD;
          end
          KIND_APPEND: begin
            cmd.append = 1'b1;
            state_next = S_DONE;
          end
          KIND_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_MRD: begin
        if (st.pos_ok) begin
          state_next = S_PRIME;
        end else begin
          cmd.miss   = 1'b1;
          state_next = st.retried ? S_DONE : S_MRD;
        end
      end
      S_PRIME: begin
        cmd.step   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (st.hit) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end else if (st.scan_end) begin
          cmd.miss   = 1'b1;
          state_next = st.retried ? S_DONE : S_MRD;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mcsm_dp.sv
// Datapath: song tables, done marks of the current moment, scan pipeline, result register.
// Depends on mcsm_pkg; driven by mcsm_ctrl commands.
module mcsm_dp #(
  parameter int MAX_MOMENTS            = mcsm_pkg::MAX_MOMENTS_DEF,
  parameter int MAX_ACTIONS            = mcsm_pkg::MAX_ACTIONS_DEF,
  parameter int MAX_ACTIONS_PER_MOMENT = mcsm_pkg::MAX_ACTIONS_PER_MOMENT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mcsm_pkg::in_item_t    in_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_data,
  input  mcsm_pkg::dp_cmd_t     cmd,
  output mcsm_pkg::dp_status_t  st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mcsm_pkg::out_item_t   out_data
);
  import mcsm_pkg::*;

  localparam int AW   = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int ACW  = $clog2(MAX_ACTIONS + 1);
  localparam int MAW  = (MAX_MOMENTS > 1) ? $clog2(MAX_MOMENTS) : 1;
  localparam int MW   = $clog2(MAX_MOMENTS + 1);
  localparam int CW   = $clog2(MAX_ACTIONS_PER_MOMENT + 2);
  localparam int JW   = (MAX_ACTIONS_PER_MOMENT > 1) ? $clog2(MAX_ACTIONS_PER_MOMENT) : 1;
  localparam int SUMW = ((AW > CW) ? AW : CW) + 1;

  logic [6:0]    note_mem [MAX_ACTIONS];
  logic [6:0]    vol_mem  [MAX_ACTIONS];
  logic [AW-1:0] first_mem[MAX_MOMENTS];
  logic [CW-1:0] cnt_mem  [MAX_MOMENTS];

  in_item_t      item;
  logic          strict;
  logic [MW-1:0] position;
  logic [MW-1:0] moment_total;
  logic [ACW-1:0] action_total;
  logic [CW-1:0] open_size;
  logic [MAX_ACTIONS_PER_MOMENT-1:0] mask;
  logic [CW-1:0] done_cnt;
  logic [CW-1:0] rd_j;
  logic [CW-1:0] cmp_j;
  logic          cmp_v;
  logic [6:0]    act_note_q;
  logic [6:0]    act_vol_q;
  logic [AW-1:0] mom_first_q;
  logic [CW-1:0] mom_cnt_q;

  logic          r_matched;
  logic [1:0]    fails;
  logic          r_mdone;
  logic          r_sdone;
  logic          r_lerr;

  logic [AW-1:0] act_rd_addr;
  logic [JW-1:0] jidx;
  logic          vol_ok;
  logic          hit;
  logic          moment_full;
  logic [MW-1:0] pos_inc;
  logic          append_ok;
  logic [AW-1:0] first_new;
  logic [CW-1:0] open_inc;

  assign act_rd_addr = AW'(SUMW'(mom_first_q) + SUMW'(rd_j));
  assign jidx        = cmp_j[JW-1:0];
  assign vol_ok      = strict ? (item.volume == act_vol_q)
                              : ((item.volume != 7'd0) == (act_vol_q != 7'd0));
  assign hit         = cmp_v && !mask[jidx] && (item.note == act_note_q) && vol_ok;
  assign moment_full = (CW'(done_cnt + 1'b1) == mom_cnt_q);
  assign pos_inc     = MW'(position + 1'b1);
  assign append_ok   = (action_total < ACW'(MAX_ACTIONS))
                    && (open_size < CW'(MAX_ACTIONS_PER_MOMENT))
                    && (moment_total < MW'(MAX_MOMENTS));
  assign first_new   = AW'(action_total - ACW'(open_size));
  assign open_inc    = CW'(open_size + 1'b1);

  always_comb begin
    st.kind     = item.kind;
    st.pos_ok   = (position < moment_total);
    st.hit      = hit;
    st.scan_end = !cmp_v;
    st.retried  = (fails != 2'd0);
    st.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.append && append_ok) begin
      note_mem[action_total[AW-1:0]] <= item.note;
      vol_mem[action_total[AW-1:0]]  <= item.volume;
      if (item.ends_moment) begin
        first_mem[moment_total[MAW-1:0]] <= first_new;
        cnt_mem[moment_total[MAW-1:0]]   <= open_inc;
      end
    end
    act_note_q  <= note_mem[act_rd_addr];
    act_vol_q   <= vol_mem[act_rd_addr];
    mom_first_q <= first_mem[position[MAW-1:0]];
    mom_cnt_q   <= cnt_mem[position[MAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
    if (cmd.emit) begin
      out_data.matched      <= r_matched;
      out_data.fail_signals <= fails;
      out_data.moment_done  <= r_mdone;
      out_data.song_done    <= r_sdone;
      out_data.position     <= POS_W'(position);
      out_data.load_error   <= r_lerr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strict       <= 1'b0;
      position     <= '0;
      moment_total <= '0;
      action_total <= '0;
      open_size    <= '0;
      mask         <= '0;
      done_cnt     <= '0;
      rd_j         <= '0;
      cmp_j        <= '0;
      cmp_v        <= 1'b0;
      r_matched    <= 1'b0;
      fails        <= 2'd0;
      r_mdone      <= 1'b0;
      r_sdone      <= 1'b0;
      r_lerr       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        strict <= cfg_data;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        r_matched <= 1'b0;
        fails     <= 2'd0;
        r_mdone   <= 1'b0;
        r_sdone   <= 1'b0;
        r_lerr    <= 1'b0;
        rd_j      <= '0;
      end
      if (cmd.step) begin
        cmp_j <= rd_j;
        cmp_v <= (rd_j < mom_cnt_q);
        rd_j  <= CW'(rd_j + 1'b1);
      end
      // miss: count the failure and restart from the first moment
      if (cmd.miss) begin
        fails    <= 2'(fails + 2'd1);
        position <= '0;
        mask     <= '0;
        done_cnt <= '0;
        rd_j     <= '0;
      end
      if (cmd.hit) begin
        r_matched <= 1'b1;
        if (moment_full) begin
          position <= pos_inc;
          mask     <= '0;
          done_cnt <= '0;
          r_mdone  <= 1'b1;
          r_sdone  <= (pos_inc == moment_total);
        end else begin
          mask[jidx] <= 1'b1;
          done_cnt   <= CW'(done_cnt + 1'b1);
        end
      end
      if (cmd.append) begin
        if (append_ok) begin
          action_total <= ACW'(action_total + 1'b1);
          if (item.ends_moment) begin
            moment_total <= MW'(moment_total + 1'b1);
            open_size    <= '0;
          end else begin
            open_size <= open_inc;
          end
        end else begin
          r_lerr <= 1'b1;
        end
      end
      if (cmd.clear) begin
        moment_total <= '0;
        action_total <= '0;
        open_size    <= '0;
        position     <= '0;
        mask         <= '0;
        done_cnt     <= '0;
      end
    end
  end

endmodule

>>> rtl/midi_chord_sequence_matcher.sv
// Channel  Signals                         Direction  Payload
// in       in_valid / in_ready / in_data   input      mcsm_pkg::in_item_t
// out      out_valid / out_ready / out_data output    mcsm_pkg::out_item_t
// cfg      cfg_valid / cfg_ready / cfg_data input     strict_volume bit
//
// One item at a time. Append, clear and unused kinds pass through the execute and done
// states to the output register; an event also scans the current moment and, after a
// miss, scans once more from the first moment.
// The scan reads one stored action per cycle from the action memory.
// Synchronous reset; tables are undefined until loaded, counts and marks clear.
// A waiting result holds the next item's transfer in its final state only.
// Top level; depends on mcsm_pkg, mcsm_ctrl, mcsm_dp.
module midi_chord_sequence_matcher #(
  parameter int MAX_MOMENTS            = mcsm_pkg::MAX_MOMENTS_DEF,
  parameter int MAX_ACTIONS            = mcsm_pkg::MAX_ACTIONS_DEF,
  parameter int MAX_ACTIONS_PER_MOMENT = mcsm_pkg::MAX_ACTIONS_PER_MOMENT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcsm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcsm_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import mcsm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = !rst;

  mcsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mcsm_dp #(
    .MAX_MOMENTS            (MAX_MOMENTS),
    .MAX_ACTIONS            (MAX_ACTIONS),
    .MAX_ACTIONS_PER_MOMENT (MAX_ACTIONS_PER_MOMENT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/tb_midi_chord_sequence_matcher.sv
`timescale 1ns / 100ps
// Self-checking testbench for midi_chord_sequence_matcher: a directed table, then random
// songs and events in three idling regimes, each result checked against the table or a local predictor.
// Depends on mcsm_pkg and the matcher RTL.
module tb_midi_chord_sequence_matcher;
  import mcsm_pkg::*;

  localparam int NUM_MOMENTS = MAX_MOMENTS_DEF;
  localparam int NUM_ACTIONS = MAX_ACTIONS_DEF;
  localparam int PER_MOMENT  = MAX_ACTIONS_PER_MOMENT_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT     = 150;

  typedef struct packed {
    in_item_t  item;
    int        reps;
    logic      typed;
    out_item_t res;
  } table_row_t;

  localparam out_item_t QUIET      = '0;
  localparam out_item_t EMPTY_MISS = '{fail_signals: 2'd2, default: '0};
  localparam out_item_t REFUSED    = '{load_error: 1'b1, default: '0};

  localparam table_row_t DIRECTED [23] = '{
    '{'{KIND_EVENT,  7'd60,  7'd100, 1'b0}, 1,          1'b1, EMPTY_MISS},
    '{'{KIND_UNUSED, 7'd127, 7'd127, 1'b1}, 1,          1'b1, QUIET},
    '{'{KIND_APPEND, 7'd0,   7'd0,   1'b0}, 1,          1'b1, QUIET},
    '{'{KIND_APPEND, 7'd127, 7'd127, 1'b1}, 1,          1'b1, QUIET},
    '{'{KIND_APPEND, 7'd60,  7'd64,  1'b1}, 1,          1'b1, QUIET},
    '{'{KIND_EVENT,  7'd127, 7'd1,   1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd0,   7'd0,   1'b1}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd60,  7'd0,   1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd0,   7'd0,   1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd127, 7'd127, 1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd60,  7'd5,   1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_APPEND, 7'd10,  7'd0,   1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_APPEND, 7'd11,  7'd1,   1'b1}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd11,  7'd5,   1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd10,  7'd0,   1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd127, 7'd127, 1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_APPEND, 7'd20,  7'd20,  1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_EVENT,  7'd20,  7'd20,  1'b0}, 1,          1'b0, QUIET},
    '{'{KIND_CLEAR,  7'd127, 7'd127, 1'b1}, 1,          1'b1, QUIET},
    '{'{KIND_EVENT,  7'd0,   7'd0,   1'b0}, 1,          1'b1, EMPTY_MISS},
    '{'{KIND_APPEND, 7'd5,   7'd5,   1'b0}, PER_MOMENT, 1'b1, QUIET},
    '{'{KIND_APPEND, 7'd5,   7'd5,   1'b1}, 1,          1'b1, REFUSED},
    '{'{KIND_CLEAR,  7'd0,   7'd0,   1'b0}, 1,          1'b1, QUIET}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  midi_chord_sequence_matcher u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [6:0] song_note [NUM_ACTIONS];
  logic [6:0] song_vol [NUM_ACTIONS];
  logic       hit_mark [NUM_ACTIONS];
  logic [7:0] moment_start [NUM_MOMENTS];
  logic [4:0] moment_len [NUM_MOMENTS];
  logic [6:0] moments_loaded = '0;
  logic [8:0] actions_loaded = '0;
  logic [4:0] open_len = '0;
  logic [6:0] play_pos = '0;
  logic       strict_vol = 1'b0;

  out_item_t verdict_q [$];
  int        items_sent = 0;
  int        results_seen = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        in_idle_pct = 0;
  int        out_idle_pct = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;

  function automatic void clear_marks();
    foreach (hit_mark[i]) hit_mark[i] = 1'b0;
  endfunction

  // Try the event on the undone actions of the moment at play_pos.
  function automatic logic test_moment(input logic [6:0] note, input logic [6:0] vol,
                                       output logic closed, output logic finished);
    logic hit;
    logic all_marked;
    int   idx;
    hit = 1'b0;
    closed = 1'b0;
    finished = 1'b0;
    if (play_pos < moments_loaded) begin
      for (int j = 0; j < moment_len[play_pos] && !hit; j++) begin
        idx = moment_start[play_pos] + j;
        if (!hit_mark[idx] && song_note[idx] == note &&
            (strict_vol ? vol == song_vol[idx] : (vol != 0) == (song_vol[idx] != 0))) begin
          hit_mark[idx] = 1'b1;
          hit = 1'b1;
        end
      end
      if (hit) begin
        all_marked = 1'b1;
        for (int j = 0; j < moment_len[play_pos]; j++)
          if (!hit_mark[moment_start[play_pos] + j]) all_marked = 1'b0;
        if (all_marked) begin
          play_pos = play_pos + 1'b1;
          closed = 1'b1;
          finished = (play_pos >= moments_loaded);
        end
      end
    end
    return hit;
  endfunction

  function automatic out_item_t match_verdict(input in_item_t it);
    out_item_t r;
    logic      closed;
    logic      finished;
    r = '0;
    case (it.kind)
      KIND_EVENT: begin
        r.matched = test_moment(it.note, it.volume, closed, finished);
        if (!r.matched) begin
          play_pos = '0;
          clear_marks();
          r.matched = test_moment(it.note, it.volume, closed, finished);
          r.fail_signals = r.matched ? 2'd1 : 2'd2;
        end
        r.moment_done = closed;
        r.song_done = finished;
      end
      KIND_APPEND: begin
        if (actions_loaded >= NUM_ACTIONS || open_len >= PER_MOMENT ||
            moments_loaded >= NUM_MOMENTS) begin
          r.load_error = 1'b1;
        end else begin
          song_note[actions_loaded] = it.note;
          song_vol[actions_loaded] = it.volume;
          hit_mark[actions_loaded] = 1'b0;
          actions_loaded = actions_loaded + 1'b1;
          open_len = open_len + 1'b1;
          if (it.ends_moment) begin
            moment_start[moments_loaded] = 8'(actions_loaded - open_len);
            moment_len[moments_loaded] = open_len;
            moments_loaded = moments_loaded + 1'b1;
            open_len = '0;
          end
        end
      end
      KIND_CLEAR: begin
        moments_loaded = '0;
        actions_loaded = '0;
        open_len = '0;
        play_pos = '0;
        clear_marks();
      end
      default: ;
    endcase
    r.position = play_pos;
    return r;
  endfunction

  function automatic in_item_t random_item(input logic [1:0] kind);
    in_item_t it;
    it.kind = kind;
    it.note = 7'($urandom_range(127));
    it.volume = 7'($urandom_range(127));
    it.ends_moment = 1'($urandom_range(1));
    return it;
  endfunction

  // Notes mostly from a narrow pool so that moments share notes.
  function automatic in_item_t random_action(input logic ends);
    in_item_t it;
    it = random_item(KIND_APPEND);
    if ($urandom_range(9) != 0) it.note = 7'(60 + $urandom_range(5));
    case ($urandom_range(3))
      0: it.volume = '0;
      1: it.volume = 7'd127;
      default: ;
    endcase
    it.ends_moment = ends;
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_res);
    out_item_t pred;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = match_verdict(it);
    verdict_q.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic write_strict(input logic value);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    strict_vol = value;
  endtask

  task automatic build_song();
    int moments;
    int acts;
    if ($urandom_range(1)) send_item(random_item(KIND_CLEAR), 1'b0, QUIET);
    moments = $urandom_range(1, 5);
    repeat (moments) begin
      acts = ($urandom_range(19) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 4);
      for (int a = 0; a < acts; a++)
        send_item(random_action(a == acts - 1), 1'b0, QUIET);
    end
    if ($urandom_range(9) == 0) send_item(random_action(1'b0), 1'b0, QUIET);
  endtask

  // Well-formed play hits an undone action of the current moment; the rest is noise.
  task automatic play_event(input logic clean);
    int       cand [$];
    int       idx;
    int       r;
    in_item_t it;
    it = random_item(KIND_EVENT);
    r = $urandom_range(99);
    if (play_pos < moments_loaded)
      for (int j = 0; j < moment_len[play_pos]; j++)
        if (!hit_mark[moment_start[play_pos] + j]) cand.push_back(moment_start[play_pos] + j);
    if (cand.size() != 0 && (clean || r < 85)) begin
      idx = cand[$urandom_range(cand.size() - 1)];
      it.note = song_note[idx];
      if (strict_vol || song_vol[idx] == 0) it.volume = song_vol[idx];
      else it.volume = 7'($urandom_range(1, 127));
      if (!clean && r >= 78) it.volume = 7'($urandom_range(127));
    end else if ($urandom_range(1)) begin
      it.note = 7'(60 + $urandom_range(5));
    end
    send_item(it, 1'b0, QUIET);
  endtask

  task automatic random_phase(input int count);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(99);
      if (moments_loaded == 0 || r < 8) build_song();
      else if (r < 14) send_item(random_item(2'($urandom_range(3))), 1'b0, QUIET);
      else play_event(1'b0);
    end
  endtask

  // Fill the action table to its limit, then try two more appends.
  task automatic fill_actions();
    send_item(random_item(KIND_CLEAR), 1'b0, QUIET);
    for (int m = 0; m < NUM_ACTIONS / PER_MOMENT; m++)
      for (int a = 0; a < PER_MOMENT; a++)
        send_item(random_action(a == PER_MOMENT - 1), 1'b0, QUIET);
    repeat (2) send_item(random_action(1'($urandom_range(1))), 1'b0, QUIET);
  endtask

  // One action per moment up to the moment limit and two more past it, then play the whole song.
  task automatic fill_moments();
    send_item(random_item(KIND_CLEAR), 1'b0, QUIET);
    repeat (NUM_MOMENTS + 2) send_item(random_action(1'b1), 1'b0, QUIET);
    repeat (NUM_MOMENTS) play_event(1'b1);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing pending: m%0d f%0d md%0d sd%0d pos%0d le%0d",
                   $realtime, out_data.matched, out_data.fail_signals, out_data.moment_done,
                   out_data.song_done, out_data.position, out_data.load_error);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.matched !== want.matched || out_data.fail_signals !== want.fail_signals ||
            out_data.moment_done !== want.moment_done || out_data.song_done !== want.song_done ||
            out_data.position !== want.position || out_data.load_error !== want.load_error)
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp m%0d f%0d md%0d sd%0d pos%0d le%0d, got m%0d f%0d md%0d sd%0d pos%0d le%0d",
                     $realtime, want.matched, want.fail_signals, want.moment_done,
                     want.song_done, want.position, want.load_error, out_data.matched,
                     out_data.fail_signals, out_data.moment_done, out_data.song_done,
                     out_data.position, out_data.load_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    clear_marks();
    in_idle_pct = 11;
    out_idle_pct = 59;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_strict(1'b0);
    foreach (DIRECTED[i])
      repeat (DIRECTED[i].reps) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].res);

    write_strict(1'b1);
    fill_actions();
    random_phase(150);

    in_idle_pct = 59;
    out_idle_pct = 11;
    write_strict(1'b0);
    fill_moments();
    random_phase(150);

    in_idle_pct = 0;
    out_idle_pct = 0;
    write_strict(1'b1);
    random_phase(150);

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
